### hw/rtl/decimal_to_lcd_segment_image_top_assert.svh
// Assertion macros for the LCD segment image checker.
// Expects signals named clk and rst in the scope where the macros are used.
`ifndef DECIMAL_TO_LCD_SEGMENT_IMAGE_TOP_ASSERT_SVH
`define DECIMAL_TO_LCD_SEGMENT_IMAGE_TOP_ASSERT_SVH

// Antecedent implies consequent, checked outside reset.
`define DLCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The expression must never hold outside reset.
`define DLCD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hw/rtl/dlcd_pkg.sv
// Shared types, constants and functions for the LCD segment image block.
// Used by dlcd_divide, dlcd_encode and the top level; has no dependencies.
package dlcd_pkg;

  localparam int VALUE_WIDTH         = 31;
  localparam int DIGITS_MAX          = 6;
  localparam int DIGIT_COUNT_DEFAULT = 6;
  localparam int SEG_BYTES           = 12;

  // Reciprocal multipliers and shifts giving floor(value / 10^k) exactly.
  localparam logic [31:0] DIV_RECIP [DIGITS_MAX+1] = '{
    32'd2147483648, 32'd3435973837, 32'd2748779070, 32'd2199023256,
    32'd3518437209, 32'd2814749768, 32'd2251799814
  };
  localparam logic [5:0] DIV_SHIFT [DIGITS_MAX+1] = '{
    6'd31, 6'd35, 6'd38, 6'd41, 6'd45, 6'd48, 6'd51
  };

  // Panel bit position for each pattern bit.
  localparam logic [3:0] RAW_BIT_OF [16] = '{
    4'd14, 4'd1, 4'd13, 4'd15, 4'd11, 4'd3, 4'd7, 4'd2,
    4'd5, 4'd9, 4'd6, 4'd10, 4'd12, 4'd8, 4'd4, 4'd0
  };

  typedef struct packed {
    logic                       valid;
    logic [DIGITS_MAX:0][3:0]   quot;
  } dlcd_quot_t;

  function automatic logic [15:0] digit_pattern(input logic [3:0] digit);
    logic [15:0] pat;
    unique case (digit)
      4'd0:    pat = 16'hFC00;
      4'd1:    pat = 16'h6000;
      4'd2:    pat = 16'hDA10;
      4'd3:    pat = 16'hF210;
      4'd4:    pat = 16'h6610;
      4'd5:    pat = 16'hB610;
      4'd6:    pat = 16'hBE10;
      4'd7:    pat = 16'hE000;
      4'd8:    pat = 16'hFE10;
      4'd9:    pat = 16'hF610;
      default: pat = 16'h0000;
    endcase
    return pat;
  endfunction

  function automatic logic [15:0] panel_order(input logic [15:0] pat);
    logic [15:0] raw;
    raw = '0;
    for (int b = 0; b < 16; b++) begin
      raw[RAW_BIT_OF[b]] = pat[b];
    end
    return raw;
  endfunction

endpackage

### hw/rtl/dlcd_divide.sv
// Quotient stage: divides the registered value by each power of ten.
// Depends on dlcd_pkg.
module dlcd_divide (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [dlcd_pkg::VALUE_WIDTH-1:0]    value,
  output dlcd_pkg::dlcd_quot_t                quot_stage
);

  logic [dlcd_pkg::DIGITS_MAX:0][3:0] quot_next;
  logic [63:0]                        prod [dlcd_pkg::DIGITS_MAX+1];

  always_comb begin
    for (int k = 0; k <= dlcd_pkg::DIGITS_MAX; k++) begin
      prod[k]      = 64'(value) * 64'(dlcd_pkg::DIV_RECIP[k]);
      quot_next[k] = 4'(prod[k] >> dlcd_pkg::DIV_SHIFT[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quot_stage.valid <= 1'b0;
    end else begin
      quot_stage.valid <= in_valid;
    end
    if (in_valid) begin
      quot_stage.quot <= quot_next;
    end
  end

endmodule

### hw/rtl/dlcd_encode.sv
// Digit and segment stage: forms each digit, looks up and permutes its
// pattern and registers the segment memory image. Depends on dlcd_pkg.
module dlcd_encode #(
  parameter int DIGIT_COUNT = dlcd_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dlcd_pkg::dlcd_quot_t                   quot_stage,
  output logic                                   done,
  output logic [dlcd_pkg::SEG_BYTES-1:0][7:0]    seg_bytes
);

  logic [dlcd_pkg::DIGITS_MAX-1:0][3:0]  digit;
  logic [dlcd_pkg::DIGITS_MAX-1:0][15:0] raw;
  logic [dlcd_pkg::SEG_BYTES-1:0][7:0]   seg_bytes_next;

  // Each digit is floor(v/10^k) - 10*floor(v/10^(k+1)), which fits in four bits.
  always_comb begin
    for (int k = 0; k < dlcd_pkg::DIGITS_MAX; k++) begin
      digit[k] = quot_stage.quot[k] - {quot_stage.quot[k+1][0], 3'b000}
                 - {quot_stage.quot[k+1][2:0], 1'b0};
      raw[k]   = (k < DIGIT_COUNT) ?
                 dlcd_pkg::panel_order(dlcd_pkg::digit_pattern(digit[k])) : 16'h0000;
    end
    for (int n = 0; n < 4; n++) begin
      for (int p = 0; p < 3; p++) begin
        seg_bytes_next[n*3+p] = {raw[4-2*p][4*n +: 4], raw[5-2*p][4*n +: 4]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= quot_stage.valid;
    end
    if (quot_stage.valid) begin
      seg_bytes <= seg_bytes_next;
    end
  end

endmodule

### hw/rtl/decimal_to_lcd_segment_image_top.sv
// The image of a word taken at a clock edge is on the outputs, with done high, once it
// has passed through the input, quotient and image registers.
// Throughput: one word per cycle; busy is high only while reset is held.
// The three-stage pipeline is input register, quotient register, image register.
// Reset is synchronous and active high and clears the valid flags and done.
// Top level of the LCD segment image block; depends on dlcd_pkg, dlcd_divide, dlcd_encode.
module decimal_to_lcd_segment_image_top #(
  parameter int DIGIT_COUNT = dlcd_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [dlcd_pkg::VALUE_WIDTH-1:0]   value,
  output logic                               done,
  output logic [7:0]                         seg_byte_0,
  output logic [7:0]                         seg_byte_1,
  output logic [7:0]                         seg_byte_2,
  output logic [7:0]                         seg_byte_5,
  output logic [7:0]                         seg_byte_6,
  output logic [7:0]                         seg_byte_7,
  output logic [7:0]                         seg_byte_10,
  output logic [7:0]                         seg_byte_11,
  output logic [7:0]                         seg_byte_12,
  output logic [7:0]                         seg_byte_15,
  output logic [7:0]                         seg_byte_16,
  output logic [7:0]                         seg_byte_17
);

  logic                                 value_valid;
  logic [dlcd_pkg::VALUE_WIDTH-1:0]     value_reg;
  dlcd_pkg::dlcd_quot_t                 quot_stage;
  logic [dlcd_pkg::SEG_BYTES-1:0][7:0]  seg_bytes;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else begin
      value_valid <= start;
    end
    if (start && !busy) begin
      value_reg <= value;
    end
  end

  dlcd_divide u_divide (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (value_valid),
    .value      (value_reg),
    .quot_stage (quot_stage)
  );

  dlcd_encode #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_encode (
    .clk        (clk),
    .rst        (rst),
    .quot_stage (quot_stage),
    .done       (done),
    .seg_bytes  (seg_bytes)
  );

  assign seg_byte_0  = seg_bytes[0];
  assign seg_byte_1  = seg_bytes[1];
  assign seg_byte_2  = seg_bytes[2];
  assign seg_byte_5  = seg_bytes[3];
  assign seg_byte_6  = seg_bytes[4];
  assign seg_byte_7  = seg_bytes[5];
  assign seg_byte_10 = seg_bytes[6];
  assign seg_byte_11 = seg_bytes[7];
  assign seg_byte_12 = seg_bytes[8];
  assign seg_byte_15 = seg_bytes[9];
  assign seg_byte_16 = seg_bytes[10];
  assign seg_byte_17 = seg_bytes[11];

endmodule

### hw/rtl/dlcd_checker.sv
// Port-level checker for the LCD segment image block, bound to the top level.
// Depends on decimal_to_lcd_segment_image_top_assert.svh.
`include "decimal_to_lcd_segment_image_top_assert.svh"

module dlcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [30:0] value,
  input logic        done,
  input logic [7:0]  seg_byte_2,
  input logic [7:0]  seg_byte_7,
  input logic [7:0]  seg_byte_12,
  input logic [7:0]  seg_byte_17
);

  logic        accept;
  logic [15:0] lsd_nibbles;

  assign accept      = start && !busy;
  assign lsd_nibbles = {seg_byte_17[7:4], seg_byte_12[7:4], seg_byte_7[7:4], seg_byte_2[7:4]};

  `DLCD_ASSERT_IMP(a_latency, accept, ##3 done, "word accepted but no result three cycles later")
  `DLCD_ASSERT_IMP(a_no_spurious, done, $past(accept, 3), "result without an accepted word")
  // The least significant digit of zero shows the nibbles 1, 5, 5 and 1.
  `DLCD_ASSERT_IMP(a_zero_image, accept && value == 31'd0, ##3 (lsd_nibbles == 16'h1551), "wrong image for zero")
  `DLCD_ASSERT_NEVER(a_last_digit_lit, done && lsd_nibbles == 16'h0000, "least significant digit is blank")

endmodule

bind decimal_to_lcd_segment_image_top dlcd_checker u_dlcd_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .value       (value),
  .done        (done),
  .seg_byte_2  (seg_byte_2),
  .seg_byte_7  (seg_byte_7),
  .seg_byte_12 (seg_byte_12),
  .seg_byte_17 (seg_byte_17)
);
